// ===== src/range_tracking_color_map_macros.svh =====
// Assertion macros for the range tracking color map.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef RANGE_TRACKING_COLOR_MAP_MACROS_SVH
`define RANGE_TRACKING_COLOR_MAP_MACROS_SVH
`ifndef SYNTHESIS
`define RTCM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTCM_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RTCM_ASSERT(label, clk, rst_n, prop, msg)
`define RTCM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== src/rtcm_pkg.sv =====
// Package for the range tracking color map: opcodes, sequencer states, constants.
// No dependencies.
`default_nettype none
package rtcm_pkg;
	localparam int PALETTE_DEPTH_DEF = 16;
	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int LOG_FRAC_BITS     = 24;
	localparam int LOG_W             = 29;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_OBSERVE = 2'd1,
		OP_MAP     = 2'd2,
		OP_WRITE   = 2'd3
	} opcode_t;

	typedef enum logic {
		CFG_SCALE_MODE   = 1'b0,
		CFG_PALETTE_SIZE = 1'b1
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG_START,
		ST_LOG_RUN,
		ST_LOG_NEXT,
		ST_PREP_DIV,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_POS,
		ST_READ0,
		ST_READ1,
		ST_BLEND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} unit_ctl_t;
endpackage
`default_nettype wire

// ===== src/rtcm_if.sv =====
// Valid/ready channel interface carrying one packed payload.
// No dependencies.
`default_nettype none
interface rtcm_if #(parameter int W = 8) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/range_tracking_color_map.sv =====
// Range tracking color map: running min/max of Q16.16 samples, palette map.
// Top level; depends on rtcm_pkg, rtcm_if, rtcm_log2, rtcm_div and the macros header.
//
// Usage:
//   in_ch  (sink)   : request {opcode, value, entry_index, entry_red/green/blue}.
//   out_ch (source) : one {red, green, blue} result per map request only.
//   cfg port        : cfg_we/cfg_index/cfg_data, register 0 scale_mode,
//                     register 1 palette_size; write only while idle.
// Clear, observe and palette write requests take effect on acceptance; the
// sequencer stays idle. A map with an empty or degenerate range, or in log
// mode with a minimum at or below zero, goes straight to the position step.
// A linear map first runs the bit-serial divider (46 quotient bits). A log
// map runs three passes of the log2 unit before it, for minimum, sample and
// maximum. One request is in work at a time; in_ch.ready is low until the
// result has been taken by the receiver.
// If the receiver stalls, the result stays in the output register and the
// next request waits for it to drain.
// Reset empties the range, sets linear mode and two entries; palette
// contents are undefined until written.
`default_nettype none
`include "range_tracking_color_map_macros.svh"
module range_tracking_color_map (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	rtcm_if.sink             in_ch,
	rtcm_if.source           out_ch
);
	import rtcm_pkg::*;

	localparam int PALETTE_DEPTH = PALETTE_DEPTH_DEF;
	localparam int IW  = $clog2(PALETTE_DEPTH);
	localparam int NW  = 46;
	localparam int DW  = 33;

	// payload unpack: {opcode, value, entry_index, r, g, b}
	logic [1:0]  opcode;
	logic [31:0] value;
	logic [3:0]  entry_index;
	logic [7:0]  entry_red, entry_green, entry_blue;
	assign {opcode, value, entry_index, entry_red, entry_green, entry_blue} = in_ch.data;

	logic        scale_mode_q;
	logic [4:0]  palette_size_q;
	logic signed [31:0] low_q, high_q, v_q;
	logic [4:0]  nm1_q;
	state_t      state_q, state_d;
	logic [1:0]  lcnt_q;
	logic [LOG_W-1:0] ll_q, lv_q, lh_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic        zero_q;
	logic [IW-1:0] idx_q, nxt_q;
	logic [8:0]  f_q;
	logic [23:0] mem [PALETTE_DEPTH];
	logic [23:0] c0_q, c1_q;
	logic [23:0] rd_q;
	logic [23:0] res_q;
	logic        out_valid_q;

	logic        accept;
	logic        log_start, log_done;
	logic [LOG_W-1:0] log_res;
	logic        div_start;
	unit_ctl_t   div_ctl;
	logic [NW-1:0] quo;
	logic [31:0] log_x;
	logic [4:0]  n_eff;
	logic signed [31:0] vc;
	logic [32:0] dv;
	logic [44:0] pos;
	logic [IW-1:0] rd_addr;
	logic        clear_req;
	logic        range_ok;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q   <= 1'b0;
			palette_size_q <= 5'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE_MODE:   scale_mode_q   <= cfg_data[0];
				CFG_PALETTE_SIZE: palette_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		n_eff = palette_size_q;
		if (n_eff < 5'd2) n_eff = 5'd2;
		if (32'(n_eff) > PALETTE_DEPTH) n_eff = 5'(PALETTE_DEPTH);
	end

	// clamp sample into range
	always_comb begin
		vc = $signed(value);
		if (vc < low_q) vc = low_q;
		if (vc > high_q) vc = high_q;
	end

	// offset of the clamped sample from the minimum, not negative while the range is non-empty
	assign dv = {vc[31], vc} - {low_q[31], low_q};

	// range tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 32'sh7FFFFFFF;
			high_q <= 32'sh80000000;
		end else if (accept && opcode == OP_CLEAR) begin
			low_q  <= 32'sh7FFFFFFF;
			high_q <= 32'sh80000000;
		end else if (accept && opcode == OP_OBSERVE) begin
			if ($signed(value) < low_q) low_q <= $signed(value);
			if ($signed(value) > high_q) high_q <= $signed(value);
		end
	end

	always_comb begin
		case (lcnt_q)
			2'd0:    log_x = low_q;
			2'd1:    log_x = v_q;
			default: log_x = high_q;
		endcase
	end

	rtcm_log2 u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(log_x),
		.done(log_done), .result(log_res)
	);

	rtcm_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_q), .den(den_q),
		.ctl(div_ctl), .quo(quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (accept && opcode == OP_MAP) begin
					if (low_q >= high_q) state_d = ST_POS;
					else if (scale_mode_q && low_q <= 0) state_d = ST_POS;
					else if (scale_mode_q) state_d = ST_LOG_START;
					else state_d = ST_PREP_DIV;
				end
			ST_LOG_START: state_d = ST_LOG_RUN;
			ST_LOG_RUN:   if (log_done) state_d = ST_LOG_NEXT;
			ST_LOG_NEXT:  state_d = (lcnt_q == 2'd2) ? ST_PREP_DIV : ST_LOG_START;
			ST_PREP_DIV:  state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_RUN;
			ST_DIV_RUN:   if (div_ctl.done || zero_q) state_d = ST_POS;
			ST_POS:       state_d = ST_READ0;
			ST_READ0:     state_d = ST_READ1;
			ST_READ1:     state_d = ST_BLEND;
			ST_BLEND:     state_d = ST_OUT;
			ST_OUT:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// unit strobes
	always_comb begin
		log_start = (state_q == ST_LOG_START);
		div_start = (state_q == ST_DIV_START) && !zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// datapath sequencing
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_MAP) begin
			v_q    <= vc;
			nm1_q  <= n_eff - 5'd1;
			lcnt_q <= 2'd0;
			zero_q <= (low_q >= high_q) || (scale_mode_q && low_q <= 0);
			num_q  <= NW'(dv);
			den_q  <= DW'(({high_q[31], high_q} - {low_q[31], low_q}));
		end
		if (state_q == ST_LOG_RUN && log_done) begin
			case (lcnt_q)
				2'd0:    ll_q <= log_res;
				2'd1:    lv_q <= log_res;
				default: lh_q <= log_res;
			endcase
		end
		if (state_q == ST_LOG_NEXT) begin
			lcnt_q <= lcnt_q + 2'd1;
			if (lcnt_q == 2'd2) begin
				num_q  <= NW'(lv_q - ll_q);
				den_q  <= DW'(lh_q - ll_q);
				zero_q <= !(lh_q > ll_q);
			end
		end
		// form num*(n-1)*512 before dividing (dv in linear mode, the log offset in log mode)
		if (state_q == ST_PREP_DIV && !zero_q && !scale_mode_q) begin
			num_q <= NW'({num_q[32:0], 9'd0} * nm1_q);
		end
		if (state_q == ST_PREP_DIV && !zero_q && scale_mode_q) begin
			num_q <= NW'({num_q[28:0], 9'd0} * nm1_q);
		end
	end

	// round the doubled quotient to the nearest position step
	assign pos = zero_q ? 45'd0 : 45'((quo + 46'd1) >> 1);

	always_ff @(posedge clk) begin
		if (state_q == ST_POS) begin
			if (pos[44:8] > 37'(nm1_q)) idx_q <= IW'(nm1_q);
			else                        idx_q <= IW'(pos[44:8]);
			if (pos[44:8] >= 37'(nm1_q)) begin
				nxt_q <= IW'(nm1_q);
				f_q   <= (pos[44:8] > 37'(nm1_q)) ? 9'd256 : {1'b0, pos[7:0]};
			end else begin
				nxt_q <= IW'(pos[44:8] + 37'd1);
				f_q   <= {1'b0, pos[7:0]};
			end
		end
	end

	// palette memory
	assign rd_addr = (state_q == ST_READ0) ? idx_q : nxt_q;
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_WRITE && 32'(entry_index) < PALETTE_DEPTH)
			mem[IW'(entry_index)] <= {entry_red, entry_green, entry_blue};
		rd_q <= mem[rd_addr];
		if (state_q == ST_READ1) c0_q <= rd_q;
		if (state_q == ST_BLEND) c1_q <= rd_q;
	end

	// blend and output register
	function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
		input logic [8:0] f);
		logic [17:0] s;
		s = 18'(a) * 18'(9'd256 - f) + 18'(b) * 18'(f) + 18'd128;
		return s[15:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_OUT) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT)
			res_q <= {mix(c0_q[23:16], c1_q[23:16], f_q),
				mix(c0_q[15:8], c1_q[15:8], f_q), mix(c0_q[7:0], c1_q[7:0], f_q)};
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = res_q;

	// terms for the checks below
	assign clear_req = accept && (opcode == OP_CLEAR);
	assign range_ok  = (low_q <= high_q);

	`RTCM_ASSERT(a_busy_no_ready, clk, arst_n, (state_q != ST_IDLE) |-> !in_ch.ready, "ready while busy")
	`RTCM_ASSERT(a_range_ok, clk, arst_n, range_ok |=> range_ok || $past(clear_req), "range inverted")
	`RTCM_ASSERT(a_out_once, clk, arst_n, (state_q == ST_OUT) |=> out_ch.valid, "result lost")
endmodule
`default_nettype wire

// ===== src/rtcm_log2.sv =====
// Iterative log2 unit: leading-one search then one squaring per fraction bit.
// Depends on rtcm_pkg.
`default_nettype none
module rtcm_log2 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [31:0]                 x,
	output logic                             done,
	output logic [rtcm_pkg::LOG_W-1:0]       result
);
	import rtcm_pkg::*;

	logic [31:0] m_q;
	logic [4:0]  e_q;
	logic [4:0]  bit_q;
	logic        busy_q;
	logic        done_q;
	logic [LOG_W-1:0] r_q;
	logic [4:0]  lead;
	logic [63:0] sq;
	logic [32:0] sq_sh;

	// find leading one
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) lead = 5'(i);
		end
	end

	assign sq    = {32'd0, m_q} * {32'd0, m_q};
	assign sq_sh = sq[63:31];

	// square mantissa, one fraction bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 5'(LOG_FRAC_BITS - 1);
			end else if (busy_q) begin
				if (bit_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				bit_q <= bit_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= x << (5'd31 - lead);
			e_q <= lead;
			r_q <= '0;
		end else if (busy_q) begin
			if (sq_sh[32]) begin
				m_q <= sq_sh[32:1];
				r_q[bit_q] <= 1'b1;
			end else begin
				m_q <= sq_sh[31:0];
			end
		end
	end

	assign done   = done_q;
	assign result = {e_q, r_q[LOG_FRAC_BITS-1:0]};
endmodule
`default_nettype wire

// ===== src/rtcm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rtcm_pkg for the control struct.
`default_nettype none
module rtcm_div #(parameter int NW = 46, parameter int DW = 33) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NW-1:0]    num,
	input  wire logic [DW-1:0]    den,
	output rtcm_pkg::unit_ctl_t   ctl,
	output logic [NW-1:0]         quo
);
	import rtcm_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], q_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	// shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
	assign quo = q_q;
endmodule
`default_nettype wire
